FILE: sv/ilm_pkg.sv
// Shared types and codes of the index linked multi-list manager.
package ilm_pkg;

   // Action codes carried in the request word.
   localparam logic [1:0] ACT_APPEND = 2'd0;
   localparam logic [1:0] ACT_REMOVE = 2'd1;
   localparam logic [1:0] ACT_POP    = 2'd2;

   // Source of the link table read address.
   typedef enum logic [1:0] {
      RD_HEAD,
      RD_NEXT,
      RD_ENT
   } rd_sel_type;

   // Link table write address.
   typedef enum logic [1:0] {
      WA_CUR,
      WA_ENT,
      WA_SWEEP
   } lk_wa_type;

   // Link table write data.
   typedef enum logic [1:0] {
      WD_ZERO,
      WD_ENT,
      WD_LINK,
      WD_INIT
   } lk_wd_type;

   // Head table write data; HD_INIT also selects the sweep address.
   typedef enum logic [1:0] {
      HD_ENT,
      HD_LINK,
      HD_INIT
   } hd_wd_type;

   typedef struct packed {
      logic       cap;
      logic       sweep;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       cur_ld;
      logic       cnt_clr;
      logic       cnt_inc;
      logic       lk_we;
      lk_wa_type  lk_wa;
      lk_wd_type  lk_wd;
      logic       hd_we;
      hd_wd_type  hd_wd;
      logic       mark_ok;
      logic       emit;
   } cmd_type;

   typedef struct packed {
      logic [1:0] act;
      logic       lst_ok;
      logic       ent_ok;
      logic       head_v;
      logic       head_is_ent;
      logic       link_v;
      logic       link_is_ent;
      logic       walk_last;
      logic       sweep_last;
      logic       out_free;
   } status_type;

endpackage

FILE: sv/ilm_datapath.sv
// Datapath of the list manager: head and link tables, walk registers, result register.
module ilm_datapath
   import ilm_pkg::*;
#(
   parameter int ENTRIES = 64,
   parameter int LISTS   = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [15:0] req_tdata,
   input  cmd_type     cmd,
   output status_type  status,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata
);

   localparam int EW    = $clog2(ENTRIES);
   localparam int LW    = (LISTS > 1) ? $clog2(LISTS) : 1;
   localparam int SWEEP = (ENTRIES > LISTS) ? ENTRIES : LISTS;
   localparam int SWW   = $clog2(SWEEP);

   typedef struct packed {
      logic          v;
      logic [EW-1:0] at;
   } ptr_type;

   ptr_type link_mem [ENTRIES];
   ptr_type head_mem [LISTS];

   logic [1:0]     act_ff;
   logic [2:0]     lst_ff;
   logic [5:0]     ent_ff;
   ptr_type        head_q_ff;
   ptr_type        link_q_ff;
   logic [EW-1:0]  cur_ff;
   logic [EW-1:0]  cnt_ff;
   logic [SWW-1:0] sw_ff;
   logic           res_ok_ff;
   logic           rsp_valid_ff;
   logic           rsp_ok_ff;
   logic [5:0]     rsp_ent_ff;

   logic [EW-1:0]  ent_idx;
   logic [EW-1:0]  rd_addr;
   logic [EW-1:0]  lk_addr;
   ptr_type        lk_data;
   logic           lk_we_eff;
   logic [LW-1:0]  hd_addr;
   ptr_type        hd_data;
   logic           hd_we_eff;
   logic [SWW:0]   sw_next;
   logic           sw_in_links;
   logic           sw_in_heads;
   ptr_type        init_link;
   logic [5:0]     eout;

   assign ent_idx     = EW'(ent_ff);
   assign sw_next     = {1'b0, sw_ff} + (SWW + 1)'(1);
   assign sw_in_links = {1'b0, sw_ff} < (SWW + 1)'(ENTRIES);
   assign sw_in_heads = {1'b0, sw_ff} < (SWW + 1)'(LISTS);
   assign init_link.v  = sw_next < (SWW + 1)'(ENTRIES);
   assign init_link.at = init_link.v ? sw_next[EW-1:0] : '0;

   always_comb begin
      case (cmd.rd_sel)
         RD_HEAD: rd_addr = head_q_ff.at;
         RD_NEXT: rd_addr = link_q_ff.at;
         RD_ENT:  rd_addr = ent_idx;
         default: rd_addr = ent_idx;
      endcase
   end

   always_comb begin
      case (cmd.lk_wa)
         WA_CUR:   lk_addr = cur_ff;
         WA_ENT:   lk_addr = ent_idx;
         WA_SWEEP: lk_addr = sw_ff[EW-1:0];
         default:  lk_addr = cur_ff;
      endcase
      case (cmd.lk_wd)
         WD_ZERO: lk_data = '0;
         WD_ENT:  lk_data = {1'b1, ent_idx};
         WD_LINK: lk_data = link_q_ff;
         WD_INIT: lk_data = init_link;
         default: lk_data = '0;
      endcase
      lk_we_eff = cmd.lk_we && ((cmd.lk_wa != WA_SWEEP) || sw_in_links);
   end

   always_comb begin
      case (cmd.hd_wd)
         HD_ENT: begin
            hd_addr = LW'(lst_ff);
            hd_data = {1'b1, ent_idx};
         end
         HD_LINK: begin
            hd_addr = LW'(lst_ff);
            hd_data = link_q_ff;
         end
         HD_INIT: begin
            hd_addr = sw_ff[LW-1:0];
            hd_data = {(sw_ff == '0), {EW{1'b0}}};
         end
         default: begin
            hd_addr = LW'(lst_ff);
            hd_data = '0;
         end
      endcase
      hd_we_eff = cmd.hd_we && ((cmd.hd_wd != HD_INIT) || sw_in_heads);
   end

   // Link table: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (lk_we_eff) begin
         link_mem[lk_addr] <= lk_data;
      end
      if (cmd.rd_en) begin
         link_q_ff <= link_mem[rd_addr];
      end
   end

   // Head table: read at the request's list when the word is taken.
   always_ff @(posedge clock) begin
      if (hd_we_eff) begin
         head_mem[hd_addr] <= hd_data;
      end
      if (cmd.cap) begin
         head_q_ff <= head_mem[LW'(req_tdata[4:2])];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cap) begin
         act_ff <= req_tdata[1:0];
         lst_ff <= req_tdata[4:2];
         ent_ff <= req_tdata[10:5];
      end
      if (cmd.cur_ld) begin
         cur_ff <= rd_addr;
      end
      if (cmd.cnt_clr) begin
         cnt_ff <= '0;
      end else if (cmd.cnt_inc) begin
         cnt_ff <= cnt_ff + EW'(1);
      end
      if (cmd.cap) begin
         res_ok_ff <= 1'b0;
      end else if (cmd.mark_ok) begin
         res_ok_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sw_ff <= '0;
      end else if (cmd.sweep) begin
         sw_ff <= sw_ff + SWW'(1);
      end
   end

   assign eout = (act_ff == ACT_POP) ? (res_ok_ff ? 6'(cur_ff) : 6'd0) : ent_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.emit) begin
         rsp_ok_ff  <= res_ok_ff;
         rsp_ent_ff <= eout;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_ent_ff, rsp_ok_ff};

   assign status.act         = act_ff;
   assign status.lst_ok      = 32'(lst_ff) < LISTS;
   assign status.ent_ok      = 32'(ent_ff) < ENTRIES;
   assign status.head_v      = head_q_ff.v;
   assign status.head_is_ent = 32'(head_q_ff.at) == 32'(ent_ff);
   assign status.link_v      = link_q_ff.v;
   assign status.link_is_ent = 32'(link_q_ff.at) == 32'(ent_ff);
   assign status.walk_last   = cnt_ff == EW'(ENTRIES - 1);
   assign status.sweep_last  = sw_ff == SWW'(SWEEP - 1);
   assign status.out_free    = !rsp_valid_ff || rsp_tready;

endmodule

FILE: sv/ilm_controller.sv
// Sequencer of the list manager: init sweep, request decode and list walk.
module ilm_controller
   import ilm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_DECIDE,
      S_WALK,
      S_HREM,
      S_RCOPY,
      S_WENT,
      S_FIN
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_INIT: begin
            cmd.sweep = 1'b1;
            cmd.lk_we = 1'b1;
            cmd.lk_wa = WA_SWEEP;
            cmd.lk_wd = WD_INIT;
            cmd.hd_we = 1'b1;
            cmd.hd_wd = HD_INIT;
            if (status.sweep_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.cap  = 1'b1;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            state_in = S_FIN;
            if (status.lst_ok) begin
               case (status.act)
                  ACT_APPEND: begin
                     if (status.ent_ok && !status.head_v) begin
                        cmd.hd_we   = 1'b1;
                        cmd.hd_wd   = HD_ENT;
                        cmd.lk_we   = 1'b1;
                        cmd.lk_wa   = WA_ENT;
                        cmd.lk_wd   = WD_ZERO;
                        cmd.mark_ok = 1'b1;
                     end else if (status.ent_ok) begin
                        cmd.rd_en   = 1'b1;
                        cmd.rd_sel  = RD_HEAD;
                        cmd.cur_ld  = 1'b1;
                        cmd.cnt_clr = 1'b1;
                        state_in    = S_WALK;
                     end
                  end
                  ACT_REMOVE: begin
                     if (status.ent_ok && status.head_v && status.head_is_ent) begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RD_ENT;
                        cmd.cur_ld = 1'b1;
                        state_in   = S_HREM;
                     end else if (status.ent_ok && status.head_v) begin
                        cmd.rd_en   = 1'b1;
                        cmd.rd_sel  = RD_HEAD;
                        cmd.cur_ld  = 1'b1;
                        cmd.cnt_clr = 1'b1;
                        state_in    = S_WALK;
                     end
                  end
                  ACT_POP: begin
                     if (status.head_v) begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RD_HEAD;
                        cmd.cur_ld = 1'b1;
                        state_in   = S_HREM;
                     end
                  end
                  default: state_in = S_FIN;
               endcase
            end
         end
         S_WALK: begin
            if (status.act == ACT_APPEND && !status.link_v) begin
               cmd.lk_we = 1'b1;
               cmd.lk_wa = WA_CUR;
               cmd.lk_wd = WD_ENT;
               state_in  = S_WENT;
            end else if (status.act != ACT_APPEND && !status.link_v) begin
               state_in = S_FIN;
            end else if (status.act != ACT_APPEND && status.link_is_ent) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_ENT;
               state_in   = S_RCOPY;
            end else if (status.walk_last) begin
               state_in = S_FIN;
            end else begin
               cmd.rd_en   = 1'b1;
               cmd.rd_sel  = RD_NEXT;
               cmd.cur_ld  = 1'b1;
               cmd.cnt_inc = 1'b1;
            end
         end
         S_HREM: begin
            cmd.hd_we   = 1'b1;
            cmd.hd_wd   = HD_LINK;
            cmd.lk_we   = 1'b1;
            cmd.lk_wa   = WA_CUR;
            cmd.lk_wd   = WD_ZERO;
            cmd.mark_ok = 1'b1;
            state_in    = S_FIN;
         end
         S_RCOPY: begin
            cmd.lk_we = 1'b1;
            cmd.lk_wa = WA_CUR;
            cmd.lk_wd = WD_LINK;
            state_in  = S_WENT;
         end
         S_WENT: begin
            cmd.lk_we   = 1'b1;
            cmd.lk_wa   = WA_ENT;
            cmd.lk_wd   = WD_ZERO;
            cmd.mark_ok = 1'b1;
            state_in    = S_FIN;
         end
         S_FIN: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_INIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);

endmodule

FILE: sv/index_linked_multi_list_manager_top.sv
// Top level of the index linked multi-list manager: controller plus datapath.
// Sequence: a pop or a head remove passes the decide, head remove and finish states, an
// append to an empty list only decide and finish; a walk reads one link entry per cycle,
// so the worst case is a walk over the whole link table.
// Flow: one request at a time; the next word is taken the cycle after the previous
// result word is loaded into the output register.
// Reset: a max(ENTRIES, LISTS) address sweep loads the tables; no word is taken before.
module index_linked_multi_list_manager_top
   import ilm_pkg::*;
#(
   parameter int ENTRIES = 64,
   parameter int LISTS   = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // Fields from bit 0: action[1:0], list_id[4:2], entry_index[10:5], zero pad [15:11].
   input  logic [15:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // Fields from bit 0: ok[0], entry_out[6:1], zero pad [7].
   output logic [7:0]  rsp_tdata
);

   // Commands flow from the sequencer to the datapath, status flows back.
   cmd_type    cmd;
   status_type status;

   // The controller owns the request handshake and steps through each action,
   // issuing at most one link table read or write per cycle.
   ilm_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // The datapath holds both tables and the result register, so a finished word
   // can wait on the output while the next request word is taken.
   ilm_datapath #(
      .ENTRIES (ENTRIES),
      .LISTS   (LISTS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // The link table is driven as one port: a read and a write never share a cycle.
   assert property (@(posedge clock) disable iff (reset) !(cmd.lk_we && cmd.rd_en))
      else $error("link table read and write in the same cycle");

   // A result is only loaded when the output register is free or draining.
   assert property (@(posedge clock) disable iff (reset) cmd.emit |-> status.out_free)
      else $error("result loaded over an unread result word");

   // Only one request is in work at a time.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while another is in work");

endmodule

FILE: tb/list_result_checker.sv
// Checker for the list manager: predicts each request word and compares the result words.
module list_result_checker
   import ilm_pkg::*;
#(
   parameter int ENTRIES = 64,
   parameter int LISTS   = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,
   output int          error_count,
   output int          pending_count,
   output int          result_count,
   output int          success_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic       ok;
      logic [5:0] entry_out;
   } outcome_type;

   // Private copy of the list tables.
   logic       head_valid [LISTS];
   logic [5:0] head_idx   [LISTS];
   logic       link_valid [ENTRIES];
   logic [5:0] link_idx   [ENTRIES];

   outcome_type pending_outcomes [$];

   task automatic load_reset_lists();
      int i;
      for (i = 0; i < LISTS; i++) begin
         head_valid[i] = 1'b0;
         head_idx[i]   = '0;
      end
      for (i = 0; i < ENTRIES; i++) begin
         link_valid[i] = (i + 1 < ENTRIES);
         link_idx[i]   = (i + 1 < ENTRIES) ? 6'(i + 1) : 6'd0;
      end
      head_valid[0] = 1'b1;
      head_idx[0]   = 6'd0;
   endtask

   // Applies one request to the tables and returns the result it gives.
   function automatic outcome_type predict_list_op(logic [1:0] act, logic [2:0] lst,
                                                   logic [5:0] ent);
      outcome_type res;
      logic [5:0]  cur;
      int          steps;
      bit          done;
      res.ok        = 1'b0;
      res.entry_out = (act == ACT_POP) ? 6'd0 : ent;
      done          = 1'b0;
      case (act)
         ACT_APPEND: begin
            if (!head_valid[lst]) begin
               head_valid[lst] = 1'b1;
               head_idx[lst]   = ent;
               link_valid[ent] = 1'b0;
               link_idx[ent]   = '0;
               res.ok          = 1'b1;
            end else begin
               cur = head_idx[lst];
               for (steps = 0; steps < ENTRIES && !done; steps++) begin
                  if (!link_valid[cur]) begin
                     link_valid[cur] = 1'b1;
                     link_idx[cur]   = ent;
                     link_valid[ent] = 1'b0;
                     link_idx[ent]   = '0;
                     res.ok          = 1'b1;
                     done            = 1'b1;
                  end else begin
                     cur = link_idx[cur];
                  end
               end
            end
         end
         ACT_REMOVE: begin
            if (head_valid[lst]) begin
               if (head_idx[lst] == ent) begin
                  head_valid[lst] = link_valid[ent];
                  head_idx[lst]   = link_idx[ent];
                  link_valid[ent] = 1'b0;
                  link_idx[ent]   = '0;
                  res.ok          = 1'b1;
               end else begin
                  cur = head_idx[lst];
                  for (steps = 0; steps < ENTRIES && !done; steps++) begin
                     if (!link_valid[cur]) begin
                        done = 1'b1;
                     end else if (link_idx[cur] == ent) begin
                        link_valid[cur] = link_valid[ent];
                        link_idx[cur]   = link_idx[ent];
                        link_valid[ent] = 1'b0;
                        link_idx[ent]   = '0;
                        res.ok          = 1'b1;
                        done            = 1'b1;
                     end else begin
                        cur = link_idx[cur];
                     end
                  end
               end
            end
         end
         ACT_POP: begin
            if (head_valid[lst]) begin
               cur             = head_idx[lst];
               head_valid[lst] = link_valid[cur];
               head_idx[lst]   = link_idx[cur];
               link_valid[cur] = 1'b0;
               link_idx[cur]   = '0;
               res.entry_out   = cur;
               res.ok          = 1'b1;
            end
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         load_reset_lists();
         pending_outcomes.delete();
         error_count   <= 0;
         result_count  <= 0;
         success_count <= 0;
      end else begin
         // The result of an older request is checked before a new request is predicted.
         if (rsp_tvalid && rsp_tready) begin
            result_count <= result_count + 1;
            if (rsp_tdata[0]) success_count <= success_count + 1;
            if (pending_outcomes.size() == 0) begin
               $display("%0t: result word %h arrived with nothing expected", $time, rsp_tdata);
               error_count <= error_count + 1;
            end else begin
               want = pending_outcomes.pop_front();
               if (rsp_tdata[0] !== want.ok || rsp_tdata[6:1] !== want.entry_out
                   || rsp_tdata[7] !== 1'b0) begin
                  $display({"%0t: result mismatch: expected ok=%0d entry=%0d pad=0, ",
                            "got ok=%0d entry=%0d pad=%0d"},
                           $time, want.ok, want.entry_out, rsp_tdata[0], rsp_tdata[6:1],
                           rsp_tdata[7]);
                  error_count <= error_count + 1;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            pending_outcomes.push_back(predict_list_op(req_tdata[1:0], req_tdata[4:2],
                                                       req_tdata[10:5]));
         end
      end
      pending_count <= pending_outcomes.size();
   end

endmodule

FILE: tb/tb.sv
// Top of the list manager testbench: clock, reset, request stimulus, result back-pressure, verdict.
module tb
   import ilm_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int         ENTRIES     = 64;
   localparam int         LISTS       = 8;
   // The action field has one code that the block does not define.
   localparam logic [1:0] ACT_BAD     = 2'd3;
   // Marks an entry that sits in no list in the stimulus bookkeeping.
   localparam int         NO_LIST     = -1;
   // Cycle limit for the run; the slowest legal run stays well under it.
   localparam int         CYCLE_LIMIT = 500000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;

   int          error_count;
   int          pending_count;
   int          result_count;
   int          success_count;

   int          cycle_count = 0;
   int          burst_left;
   int          n_append, n_remove, n_pop, n_bad;

   // Stimulus bookkeeping: which list owns each entry, and a tag that orders the
   // members of a list from head to tail. It is only valid while every append uses
   // a free entry, so it steers the well-formed part and is dropped for the noise part.
   int          owner     [ENTRIES];
   int unsigned order_tag [ENTRIES];
   int unsigned next_tag;

   // Receiver back-pressure state.
   int          stall_mode = 0;
   int          stall_hold = 0;
   int          mode_timer = 0;

   index_linked_multi_list_manager_top #(
      .ENTRIES (ENTRIES),
      .LISTS   (LISTS)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   list_result_checker #(
      .ENTRIES (ENTRIES),
      .LISTS   (LISTS)
   ) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .error_count   (error_count),
      .pending_count (pending_count),
      .result_count  (result_count),
      .success_count (success_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Guard against a hung block: the run ends once the cycle count reaches the limit.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: errors");
         $finish;
      end
   end

   // The receiver runs its own pattern, changed when its random mode timer runs out:
   // always ready, ready on a coin toss, or alternating runs of ready and stalled.
   always @(negedge clock) begin
      if (mode_timer == 0) begin
         stall_mode = $urandom_range(0, 2);
         mode_timer = $urandom_range(50, 300);
      end else begin
         mode_timer--;
      end
      case (stall_mode)
         0: rsp_tready = 1'b1;
         1: rsp_tready = 1'($urandom_range(0, 1));
         default: begin
            if (stall_hold == 0) begin
               rsp_tready = ~rsp_tready;
               stall_hold = $urandom_range(1, 8);
            end else begin
               stall_hold--;
            end
         end
      endcase
   end

   // Presents one request word at a falling edge and holds it until the block takes it.
   // The sender works in bursts: when a burst is used up, valid drops for a random gap.
   // Within a burst valid stays high from one word to the next without a dip.
   task automatic send_word(input logic [1:0] act, input logic [2:0] lst,
                            input logic [5:0] ent);
      req_tdata  = {5'd0, ent, lst, act};
      req_tvalid = 1'b1;
      case (act)
         ACT_APPEND: n_append++;
         ACT_REMOVE: n_remove++;
         ACT_POP:    n_pop++;
         default:    n_bad++;
      endcase
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         // Now and then a long burst gives a stretch without sender gaps.
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80)
                                                  : $urandom_range(1, 16);
      end
   endtask

   // Sends a well-formed request and keeps the bookkeeping in step with it.
   task automatic issue(input logic [1:0] act, input int lst, input int ent);
      int i;
      int oldest;
      oldest = -1;
      case (act)
         ACT_APPEND: begin
            if (owner[ent] == NO_LIST) begin
               owner[ent]     = lst;
               order_tag[ent] = next_tag;
               next_tag++;
            end
         end
         ACT_REMOVE: begin
            if (owner[ent] == lst) owner[ent] = NO_LIST;
         end
         ACT_POP: begin
            for (i = 0; i < ENTRIES; i++) begin
               if (owner[i] == lst && (oldest < 0 || order_tag[i] < order_tag[oldest]))
                  oldest = i;
            end
            if (oldest >= 0) owner[oldest] = NO_LIST;
         end
         default: begin
         end
      endcase
      send_word(act, lst[2:0], ent[5:0]);
   endtask

   initial begin
      int i, k, lst, ent, pick, count, roll;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      n_append   = 0;
      n_remove   = 0;
      n_pop      = 0;
      n_bad      = 0;
      burst_left = $urandom_range(1, 16);
      // After reset list 0 holds every entry in index order.
      for (i = 0; i < ENTRIES; i++) begin
         owner[i]     = 0;
         order_tag[i] = i;
      end
      next_tag = ENTRIES;
      repeat (5) @(negedge clock);
      reset = 1'b0;

      // Directed part. The block sweeps its tables after reset; send_word simply
      // waits for ready, so no fixed delay is needed here.
      issue(ACT_POP,    0, 0);    // pop the head of the full list
      issue(ACT_POP,    7, 63);   // pop from an empty list
      issue(ACT_REMOVE, 3, 5);    // remove from an empty list
      issue(ACT_REMOVE, 0, 0);    // remove an absent entry, walks the whole list
      issue(ACT_APPEND, 7, 0);    // append to an empty list
      issue(ACT_POP,    0, 0);
      issue(ACT_APPEND, 7, 1);    // append after a single entry
      issue(ACT_REMOVE, 0, 63);   // remove the tail of a long list
      issue(ACT_APPEND, 7, 63);
      issue(ACT_REMOVE, 0, 32);   // remove from the middle
      issue(ACT_APPEND, 0, 32);   // long walk to the tail
      issue(ACT_REMOVE, 7, 0);    // remove the head
      issue(ACT_REMOVE, 7, 1);
      issue(ACT_BAD,    5, 42);   // undefined action code
      issue(ACT_BAD,    7, 63);   // every field bit set
      issue(ACT_POP,    7, 0);
      issue(ACT_POP,    7, 0);    // list just emptied
      issue(ACT_APPEND, 1, 0);
      issue(ACT_APPEND, 1, 1);
      issue(ACT_APPEND, 1, 63);
      issue(ACT_REMOVE, 1, 1);
      issue(ACT_POP,    1, 0);
      issue(ACT_POP,    0, 21);

      // Well-formed random part: appends use free entries and most removes name a member,
      // so the lists keep changing shape. List 0 gets extra traffic for long walks.
      for (k = 0; k < 600; k++) begin
         lst  = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(0, LISTS - 1);
         roll = $urandom_range(0, 99);
         if (roll < 40) begin
            count = 0;
            for (i = 0; i < ENTRIES; i++) if (owner[i] == NO_LIST) count++;
            if (count == 0) begin
               issue(ACT_POP, lst, $urandom_range(0, ENTRIES - 1));
            end else begin
               pick = $urandom_range(0, count - 1);
               ent  = 0;
               for (i = 0; i < ENTRIES; i++) begin
                  if (owner[i] == NO_LIST) begin
                     if (pick == 0) ent = i;
                     pick--;
                  end
               end
               issue(ACT_APPEND, lst, ent);
            end
         end else if (roll < 70) begin
            count = 0;
            for (i = 0; i < ENTRIES; i++) if (owner[i] == lst) count++;
            ent = $urandom_range(0, ENTRIES - 1);
            if (count > 0 && $urandom_range(0, 9) < 8) begin
               pick = $urandom_range(0, count - 1);
               for (i = 0; i < ENTRIES; i++) begin
                  if (owner[i] == lst) begin
                     if (pick == 0) ent = i;
                     pick--;
                  end
               end
            end
            issue(ACT_REMOVE, lst, ent);
         end else if (roll < 97) begin
            issue(ACT_POP, lst, $urandom_range(0, ENTRIES - 1));
         end else begin
            issue(ACT_BAD, lst, $urandom_range(0, ENTRIES - 1));
         end
      end

      // Noise part: every field at random, including appends of entries already listed.
      for (k = 0; k < 100; k++) begin
         send_word(2'($urandom_range(0, 3)), 3'($urandom_range(0, LISTS - 1)),
                   6'($urandom_range(0, ENTRIES - 1)));
      end
      req_tvalid = 1'b0;

      // Drain: wait for every predicted result, then run on past it so that a stray
      // extra result word would still be caught.
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (ENTRIES + 20) @(posedge clock);

      $display("tb summary: %0d request words (%0d append, %0d remove, %0d pop, %0d undefined)",
               n_append + n_remove + n_pop + n_bad, n_append, n_remove, n_pop, n_bad);
      $display("tb summary: %0d result words checked, %0d reported success",
               result_count, success_count);
      if (error_count == 0 && pending_count == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule
